// ===== sv/compacting_list_store_macros.svh =====
// Assertion macros for the compacting list store.
// Included by the controller and datapath modules; no other dependencies.
`ifndef COMPACTING_LIST_STORE_MACROS_SVH
`define COMPACTING_LIST_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define CLS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CLS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CLS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CLS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/cls_pkg.sv =====
// Shared types and constants for the compacting list store.
// No dependencies; imported by cls_ctrl, cls_datapath and the top level.
`default_nettype none

package cls_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_APPEND     = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_AT  = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_VAL = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_SCAN,
      ST_SHIFT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                load;
      logic                ptr_index;
      logic                ptr_zero;
      logic                ptr_inc;
      logic                wr_append;
      logic                wr_shift;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cap_result;
      logic                set_status;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            index_oob;
      logic            ptr_end;
      logic            match;
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/cls_ctrl.sv =====
// Controller state machine for the compacting list store.
// Depends on cls_pkg and compacting_list_store_macros.svh.
`default_nettype none
`include "compacting_list_store_macros.svh"

module cls_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cls_pkg::stat_type stat,
   output cls_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import cls_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (stat.op)
               OP_APPEND: begin
                  if (stat.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_FULL;
                  end else begin
                     cmd.wr_append = 1'b1;
                     cmd.cnt_inc   = 1'b1;
                  end
                  state_in = ST_RESPOND;
               end
               OP_READ, OP_REMOVE_AT: begin
                  if (stat.index_oob) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STATUS_RANGE;
                     state_in       = ST_RESPOND;
                  end else begin
                     cmd.ptr_index = 1'b1;
                     state_in      = ST_FETCH;
                  end
               end
               default: begin
                  cmd.ptr_zero = 1'b1;
                  state_in     = ST_SCAN;
               end
            endcase
         end
         ST_FETCH: begin
            cmd.cap_result = 1'b1;
            if (stat.op == OP_READ) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = ST_SHIFT;
            end
         end
         ST_SCAN: begin
            if (stat.ptr_end) begin
               cmd.set_status = 1'b1;
               cmd.status     = STATUS_NOT_FOUND;
               state_in       = ST_RESPOND;
            end else if (stat.match) begin
               cmd.cap_result = 1'b1;
               cmd.ptr_inc    = 1'b1;
               state_in       = ST_SHIFT;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (stat.ptr_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_RESPOND;
            end else begin
               cmd.wr_shift = 1'b1;
               cmd.ptr_inc  = 1'b1;
            end
         end
         ST_RESPOND: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CLS_ASSERT_NXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `CLS_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `CLS_ASSERT_NXT(a_strobe_then_idle, clock, reset, rsp_strobe, !busy)

endmodule

`default_nettype wire

// ===== sv/cls_datapath.sv =====
// Datapath: entry memory, count, pointer and response registers.
// Depends on cls_pkg and compacting_list_store_macros.svh; driven by cls_ctrl.
`default_nettype none
`include "compacting_list_store_macros.svh"

module cls_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cls_pkg::cmd_type             cmd,
   input  wire logic [cls_pkg::OP_W-1:0]     req_operation,
   input  wire logic [cls_pkg::INDEX_W-1:0]  req_index,
   input  wire logic signed [cls_pkg::DATA_W-1:0] req_element_value,
   output cls_pkg::stat_type                 stat,
   output logic signed [cls_pkg::DATA_W-1:0] rsp_result_value,
   output logic [cls_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cls_pkg::COUNT_W-1:0]       rsp_count_after
);
   import cls_pkg::*;

   logic [DATA_W-1:0]   entry_mem [CAPACITY];

   logic [OP_W-1:0]     op_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [DATA_W-1:0]   value_ff;
   logic [DATA_W-1:0]   result_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    ptr_in;
   logic [CNT_W-1:0]    ptr_prev;
   logic [DATA_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                wr_en;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_index) begin
         ptr_in = CNT_W'(index_ff);
      end else if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign ptr_prev = ptr_ff - CNT_W'(1);
   assign rd_addr  = ptr_in[ADDR_W-1:0];
   assign wr_en    = cmd.wr_append | cmd.wr_shift;
   assign wr_addr  = cmd.wr_append ? count_ff[ADDR_W-1:0] : ptr_prev[ADDR_W-1:0];
   assign wr_data  = cmd.wr_append ? value_ff : rd_data_ff;

   // shift writes land below the pointer, so a read never sees a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         op_ff     <= req_operation;
         index_ff  <= req_index;
         value_ff  <= req_element_value;
         result_ff <= '0;
         status_ff <= STATUS_OK;
      end else begin
         if (cmd.cap_result) begin
            result_ff <= rd_data_ff;
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.full      = (count_ff == CNT_W'(CAPACITY));
      stat.index_oob = (32'(index_ff) >= 32'(count_ff));
      stat.ptr_end   = (ptr_ff >= count_ff);
      stat.match     = (rd_data_ff == value_ff);
   end

   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;
   assign rsp_count_after  = COUNT_W'(count_ff);

   `CLS_ASSERT_IMP(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `CLS_ASSERT_IMP(a_append_room, clock, reset, cmd.wr_append, count_ff < CNT_W'(CAPACITY))
   `CLS_ASSERT_IMP(a_shift_in_list, clock, reset, cmd.wr_shift, ptr_ff != '0 && ptr_ff < count_ff)
   `CLS_ASSERT_IMP(a_remove_nonempty, clock, reset, cmd.cnt_dec, count_ff != '0)

endmodule

`default_nettype wire

// ===== sv/compacting_list_store.sv =====
// Channel     Ports                                          Handshake
// request     req_operation, req_index, req_element_value    start & !busy
// response    rsp_result_value, rsp_status, rsp_count_after  rsp_strobe, one cycle
//
// One transaction at a time; busy is high from acceptance until the strobe cycle ends.
// Append and range or full errors pass from CHECK to RESPOND; a read also passes FETCH.
// Remove-at passes CHECK, FETCH and SHIFT, one memory move per cycle, then RESPOND.
// Remove-value scans from entry 0 to a match, then shifts; if not found, it responds at the end.
// Synchronous reset empties the list; the entry memory is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
//
// Top level of the compacting list store: joins cls_ctrl and cls_datapath.
// Depends on cls_pkg.
`default_nettype none

module compacting_list_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [cls_pkg::OP_W-1:0]            req_operation,
   input  wire logic [cls_pkg::INDEX_W-1:0]         req_index,
   input  wire logic signed [cls_pkg::DATA_W-1:0]   req_element_value,
   output logic                                     rsp_strobe,
   output logic signed [cls_pkg::DATA_W-1:0]        rsp_result_value,
   output logic [cls_pkg::STATUS_W-1:0]             rsp_status,
   output logic [cls_pkg::COUNT_W-1:0]              rsp_count_after
);
   import cls_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cls_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_index         (req_index),
      .req_element_value (req_element_value),
      .stat              (stat),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_count_after   (rsp_count_after)
   );

endmodule

`default_nettype wire
